// ===== rtl/core/lphs_pkg.sv =====
// Shared types, codes and default sizes for the linear-probe hash set.
// Depends on nothing; the top level, controller and datapath refer to it by scoped names.
`timescale 1ns / 1ps

package lphs_pkg;

	// default sizes, handed to the top-level parameters
	localparam int SLOTS_DEF       = 512;
	localparam int ENTRY_BYTES_DEF = 8;

	// fixed field widths
	localparam int MODE_W   = 3;
	localparam int ENTRY_W  = 64;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 9;
	localparam int COUNT_W  = 10;
	localparam int THRESH_W = 10;

	localparam logic [THRESH_W-1:0] THRESH_RST = 10'd358;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_FIND  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LAST  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_END       = 3'd4;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ENTRY_W-1:0] entry;
	} item_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  entry_out;
		logic [SLOT_W-1:0]   slot;
		logic [COUNT_W-1:0]  count;
	} item_out_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic load;
		logic hash_start;
		logic walk_start;
		logic walk;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic is_probe;
		logic is_scan;
		logic ent_zero;
		logic next_end;
		logic hash_done;
		logic walk_stop;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/linear_probe_hash_set.sv =====
// Top level of the linear-probe hash set: controller, datapath and threshold port.
// Depends on lphs_pkg, lphs_ctrl, lphs_dp (and through it lphs_ram).
`timescale 1ns / 1ps

// Open-addressed set of SLOTS entries of ENTRY_BYTES bytes in one RAM, where an all-zero
// slot is empty and an entry's home slot is its low 32 bits modulo SLOTS. One word is taken
// at a time: add and find probe upward from the home slot with wrap, first and next scan
// upward from slot 0 or past the cursor, last scans downward from the top. The walk reads one
// slot per cycle through the table's single read port. An add or find first finds its home slot,
// by a mask when SLOTS is a power of two and otherwise by a reciprocal multiplication, then
// walks; a scan walks at once. Zero add and find entries, unknown modes and next at the top
// slot skip the walk and go straight to the result. Results sit in an output register, so a word
// is taken while the previous result waits, and a finished result waits for the register
// to free. After reset a clearing pass writes zero to every slot, during which no word is
// taken; threshold writes on the configuration channel are taken in any cycle.

module linear_probe_hash_set #(
	parameter int SLOTS       = lphs_pkg::SLOTS_DEF,
	parameter int ENTRY_BYTES = lphs_pkg::ENTRY_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  lphs_pkg::item_in_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output lphs_pkg::item_out_t           out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lphs_pkg::THRESH_W-1:0] cfg_data
);

	lphs_pkg::cmd_t cmd;
	lphs_pkg::sts_t sts;

	// threshold register takes a word whenever one is offered
	assign cfg_ready = 1'b1;

	// sequencing: clear pass, decode, hash, walk, commit
	lphs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, walker, architectural state and output register
	lphs_dp #(
		.SLOTS       (SLOTS),
		.ENTRY_BYTES (ENTRY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data)
	);

	// never overwrite a result that has not been taken
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed while output register busy");

	// a committed result shows on the output in the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

	// one word in flight: acceptance closes the input until the item is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input reopened right after acceptance");

	// an existing entry is always returned, and is never zero
	a_exists_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.status == lphs_pkg::ST_EXISTS)) |-> (out_item.entry_out != '0))
		else $error("exists result without its entry");

endmodule

// ===== rtl/core/lphs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module lphs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/lphs_ctrl.sv =====
// Sequencing state machine of the hash set: clear pass, decode, hash, walk, commit.
// Depends on lphs_pkg for the command and status structs.
`timescale 1ns / 1ps

module lphs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lphs_pkg::sts_t sts,
	output lphs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_HASH,
		S_WALK,
		S_COMMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clear_step = 1'b1;
			S_IDLE: cmd.load = in_valid;
			S_DECODE: begin
				if (sts.is_probe && !sts.ent_zero) begin
					cmd.hash_start = 1'b1;
				end else if (sts.is_scan && !sts.next_end) begin
					cmd.walk_start = 1'b1;
				end
			end
			S_HASH: cmd.walk_start = sts.hash_done;
			S_WALK: cmd.walk = 1'b1;
			S_COMMIT: cmd.commit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clear_last) state_q <= S_IDLE;
				S_IDLE: if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					priority if (sts.is_probe && !sts.ent_zero) begin
						state_q <= S_HASH;
					end else if (sts.is_scan && !sts.next_end) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_HASH: if (sts.hash_done) state_q <= S_WALK;
				S_WALK: if (sts.walk_stop) state_q <= S_COMMIT;
				S_COMMIT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

endmodule

// ===== rtl/core/lphs_dp.sv =====
// Datapath of the hash set: slot table, home-slot hash, slot walker, state and result register.
// Depends on lphs_pkg and lphs_ram.
`timescale 1ns / 1ps

module lphs_dp #(
	parameter int SLOTS       = lphs_pkg::SLOTS_DEF,
	parameter int ENTRY_BYTES = lphs_pkg::ENTRY_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lphs_pkg::cmd_t                    cmd,
	output lphs_pkg::sts_t                    sts,
	input  lphs_pkg::item_in_t                in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lphs_pkg::item_out_t               out_item,
	input  logic                              cfg_we,
	input  logic [lphs_pkg::THRESH_W-1:0]     cfg_data
);

	localparam int EW    = 8 * ENTRY_BYTES;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > lphs_pkg::THRESH_W) ? CNT_W : lphs_pkg::THRESH_W;
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

	// latched item and architectural state
	logic [lphs_pkg::MODE_W-1:0]   mode_q;
	logic [EW-1:0]                 ent_q;
	logic [CNT_W-1:0]              count_q;
	logic [IDX_W-1:0]              cursor_q;
	logic                          cvalid_q;
	logic [lphs_pkg::THRESH_W-1:0] thresh_q;
	logic [IDX_W-1:0]              clr_addr_q;

	// walker
	logic [IDX_W-1:0] rd_addr_q;
	logic [IDX_W-1:0] data_addr_q;
	logic             rdv_q;
	logic [CNT_W-1:0] rem_q;
	logic             down_q;

	// what the walk stopped on
	logic             fnd_match_q;
	logic             fnd_empty_q;
	logic             fnd_occ_q;
	logic [IDX_W-1:0] fnd_addr_q;
	logic [EW-1:0]    fnd_data_q;

	logic                  out_valid_q;
	lphs_pkg::item_out_t   out_q;

	logic [EW-1:0]    rdata;
	logic [IDX_W-1:0] home;
	logic             hash_done;
	logic             is_probe;
	logic             is_scan;
	logic             ent_zero;
	logic             rd_zero;
	logic             rd_match;
	logic             hit;
	logic             walk_stop;
	logic [CNT_W-1:0] nxt_from;
	logic             next_end;
	logic [IDX_W-1:0] start_addr;
	logic [CNT_W-1:0] start_rem;
	logic             full;
	logic             ins;
	logic             upd_cur;
	logic [IDX_W-1:0] cur_d;
	lphs_pkg::item_out_t res;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [EW-1:0]    ram_wdata;

	lphs_ram #(
		.WIDTH (EW),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	// home slot: a mask for a power-of-two table, else a reciprocal multiplication
	if ((SLOTS & (SLOTS - 1)) == 0) begin : g_hash_mask
		assign home      = ent_q[IDX_W-1:0];
		assign hash_done = 1'b1;
	end else begin : g_hash_recip
		// quotient = x * RECIP >> RSH is exact for every 32-bit x; home = x - quotient * SLOTS
		localparam int RSH = 32 + IDX_W;
		localparam logic [63:0] RECIP_FULL = ((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
		localparam logic [32:0] RECIP = RECIP_FULL[32:0];
		localparam logic [31:0] DIV = 32'(SLOTS);
		localparam logic [1:0] HASH_CYC = 2'd3;
		logic [1:0]       hcnt_q;
		logic [64:0]      prod_q;
		logic [IDX_W-1:0] hrem_q;
		logic [15:0]      mul_a;
		logic [48:0]      part;
		logic [64:0]      quo_w;
		logic [31:0]      quo;
		logic [31:0]      rem32;

		// low half of the key first, then the high half, then the remainder
		always_comb begin
			mul_a = (hcnt_q == HASH_CYC) ? ent_q[15:0] : ent_q[31:16];
			part  = 49'(mul_a) * 49'(RECIP);
			quo_w = prod_q >> RSH;
			quo   = quo_w[31:0];
			rem32 = ent_q[31:0] - quo * DIV;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hcnt_q <= '0;
			end else if (cmd.hash_start) begin
				hcnt_q <= HASH_CYC;
			end else if (hcnt_q != 2'd0) begin
				hcnt_q <= hcnt_q - 2'd1;
			end
		end

		always_ff @(posedge clk) begin
			if (hcnt_q == HASH_CYC) begin
				prod_q <= 65'(part);
			end else if (hcnt_q == 2'd2) begin
				prod_q <= prod_q + (65'(part) << 16);
			end else if (hcnt_q == 2'd1) begin
				hrem_q <= rem32[IDX_W-1:0];
			end
		end

		assign home      = hrem_q;
		assign hash_done = (hcnt_q == 2'd0);
	end

	always_comb begin
		is_probe = (mode_q == lphs_pkg::MODE_ADD) || (mode_q == lphs_pkg::MODE_FIND);
		is_scan  = (mode_q == lphs_pkg::MODE_FIRST) || (mode_q == lphs_pkg::MODE_NEXT) ||
		           (mode_q == lphs_pkg::MODE_LAST);
		ent_zero = (ent_q == '0);
		next_end = (mode_q == lphs_pkg::MODE_NEXT) && cvalid_q && (cursor_q == LAST_IDX);
		nxt_from = cvalid_q ? (CNT_W'(cursor_q) + CNT_W'(1)) : '0;

		rd_zero   = (rdata == '0);
		rd_match  = (rdata == ent_q);
		hit       = is_probe ? (rd_zero || rd_match) : !rd_zero;
		walk_stop = rdv_q && (hit || (rem_q == CNT_W'(1)));

		unique case (mode_q)
			lphs_pkg::MODE_FIRST: begin
				start_addr = '0;
				start_rem  = SLOTS_CNT;
			end
			lphs_pkg::MODE_NEXT: begin
				start_addr = nxt_from[IDX_W-1:0];
				start_rem  = SLOTS_CNT - nxt_from;
			end
			lphs_pkg::MODE_LAST: begin
				start_addr = LAST_IDX;
				start_rem  = SLOTS_CNT;
			end
			default: begin
				start_addr = home;
				start_rem  = SLOTS_CNT;
			end
		endcase
	end

	// result and state update of the item, applied on commit
	always_comb begin
		full = (CMP_W'(count_q) > CMP_W'(thresh_q)) || (count_q >= SLOTS_CNT);
		res           = '0;
		res.status    = lphs_pkg::ST_INVALID;
		res.count     = lphs_pkg::COUNT_W'(count_q);
		ins           = 1'b0;
		upd_cur       = 1'b0;
		cur_d         = cursor_q;
		if (!is_probe && !is_scan) begin
			res.slot = lphs_pkg::SLOT_W'(cursor_q);
		end else if (is_probe) begin
			if (ent_zero) begin
				res.status = lphs_pkg::ST_INVALID;
			end else if (fnd_match_q) begin
				upd_cur       = 1'b1;
				cur_d         = fnd_addr_q;
				res.slot      = lphs_pkg::SLOT_W'(fnd_addr_q);
				res.entry_out = lphs_pkg::ENTRY_W'(fnd_data_q);
				res.status    = (mode_q == lphs_pkg::MODE_ADD) ? lphs_pkg::ST_EXISTS
				                                               : lphs_pkg::ST_OK;
			end else if (fnd_empty_q) begin
				upd_cur  = 1'b1;
				cur_d    = fnd_addr_q;
				res.slot = lphs_pkg::SLOT_W'(fnd_addr_q);
				if (mode_q == lphs_pkg::MODE_FIND) begin
					res.status = lphs_pkg::ST_NOT_FOUND;
				end else if (full) begin
					res.status = lphs_pkg::ST_FULL;
				end else begin
					ins        = 1'b1;
					res.status = lphs_pkg::ST_OK;
					res.count  = lphs_pkg::COUNT_W'(count_q + CNT_W'(1));
				end
			end else begin
				upd_cur    = 1'b1;
				cur_d      = home;
				res.slot   = lphs_pkg::SLOT_W'(home);
				res.status = (mode_q == lphs_pkg::MODE_ADD) ? lphs_pkg::ST_FULL
				                                            : lphs_pkg::ST_NOT_FOUND;
			end
		end else begin
			if (fnd_occ_q) begin
				upd_cur       = 1'b1;
				cur_d         = fnd_addr_q;
				res.slot      = lphs_pkg::SLOT_W'(fnd_addr_q);
				res.entry_out = lphs_pkg::ENTRY_W'(fnd_data_q);
				res.status    = lphs_pkg::ST_OK;
			end else begin
				res.status = lphs_pkg::ST_END;
				res.slot   = (mode_q == lphs_pkg::MODE_LAST) ? '0 : lphs_pkg::SLOT_W'(LAST_IDX);
			end
		end
	end

	always_comb begin
		ram_we    = cmd.clear_step || (cmd.commit && ins);
		ram_waddr = cmd.clear_step ? clr_addr_q : fnd_addr_q;
		ram_wdata = cmd.clear_step ? '0 : ent_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			cvalid_q    <= 1'b0;
			thresh_q    <= lphs_pkg::THRESH_RST;
			clr_addr_q  <= '0;
			rdv_q       <= 1'b0;
			rem_q       <= '0;
			down_q      <= 1'b0;
			fnd_match_q <= 1'b0;
			fnd_empty_q <= 1'b0;
			fnd_occ_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_data;
			end
			if (cmd.clear_step) begin
				clr_addr_q <= (clr_addr_q == LAST_IDX) ? '0 : clr_addr_q + IDX_W'(1);
			end
			if (cmd.load) begin
				fnd_match_q <= 1'b0;
				fnd_empty_q <= 1'b0;
				fnd_occ_q   <= 1'b0;
			end
			if (cmd.walk_start) begin
				rdv_q  <= 1'b0;
				rem_q  <= start_rem;
				down_q <= (mode_q == lphs_pkg::MODE_LAST);
			end else if (cmd.walk) begin
				rdv_q <= 1'b1;
				if (rdv_q) begin
					rem_q <= rem_q - CNT_W'(1);
				end
				if (walk_stop) begin
					fnd_match_q <= is_probe && rd_match;
					fnd_empty_q <= is_probe && rd_zero;
					fnd_occ_q   <= !is_probe && !rd_zero;
				end
			end
			if (cmd.commit) begin
				if (upd_cur) begin
					cursor_q <= cur_d;
					cvalid_q <= 1'b1;
				end
				if (ins) begin
					count_q <= count_q + CNT_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_item.mode;
			ent_q  <= in_item.entry[EW-1:0];
		end
		if (cmd.walk_start) begin
			rd_addr_q <= start_addr;
		end else if (cmd.walk) begin
			data_addr_q <= rd_addr_q;
			if (down_q) begin
				rd_addr_q <= (rd_addr_q == '0) ? LAST_IDX : rd_addr_q - IDX_W'(1);
			end else begin
				rd_addr_q <= (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + IDX_W'(1);
			end
			if (walk_stop) begin
				fnd_addr_q <= data_addr_q;
				fnd_data_q <= rdata;
			end
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_comb begin
		sts.clear_last = (clr_addr_q == LAST_IDX);
		sts.is_probe   = is_probe;
		sts.is_scan    = is_scan;
		sts.ent_zero   = ent_zero;
		sts.next_end   = next_end;
		sts.hash_done  = hash_done;
		sts.walk_stop  = walk_stop;
		sts.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for linear_probe_hash_set: random and directed words against a local model.
// Depends on lphs_pkg and the linear_probe_hash_set RTL; nothing else.
`timescale 1ns / 1ps

module tb;
	import lphs_pkg::*;

	localparam int SLOTS        = SLOTS_DEF;
	localparam int ENTRY_BYTES  = ENTRY_BYTES_DEF;
	localparam logic [ENTRY_W-1:0] ENTRY_MASK = (ENTRY_BYTES >= 8) ? '1 :
		((64'd1 << (8 * ENTRY_BYTES)) - 64'd1);

	// mode codes with no meaning to the block: each must come back as invalid
	localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

	// quiet cycles after the last result before the next phase starts
	localparam int SETTLE_CYCLES = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                in_valid = 1'b0;
	logic                in_ready;
	item_in_t            in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	item_out_t           out_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [THRESH_W-1:0] cfg_data = '0;

	// words waiting to be offered, results the set owes us, entries we have tried to add
	item_in_t        word_q[$];
	item_out_t       result_q[$];
	logic [63:0]     added_q[$];
	int              pending_results = 0;
	int              n_mismatch = 0;
	int              send_gap_pct = 0;
	int              recv_stall_pct = 0;

	// local copy of the set's state
	logic [ENTRY_W-1:0] slot_mem [SLOTS];
	int                 n_stored;
	int                 cur_pos;
	bit                 cur_set;
	int                 thresh;

	always #5 clk = ~clk;

	linear_probe_hash_set #(
		.SLOTS(SLOTS),
		.ENTRY_BYTES(ENTRY_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Apply one word to the local set and return the result the block owes for it.
	function automatic item_out_t apply_op(item_in_t w);
		item_out_t          o;
		logic [ENTRY_W-1:0] e;
		logic [31:0]        lo;
		int                 home, p, n, hit, at;
		o = '0;
		o.status = ST_INVALID;
		e = w.entry & ENTRY_MASK;
		case (w.mode)
			MODE_ADD, MODE_FIND: begin
				// a zero entry would read as an empty slot: refuse it, touch nothing
				if (e != '0) begin
					lo = e[31:0];
					home = int'(lo % SLOTS);
					p = home;
					at = home;
					hit = -1;
					// walk upward with wrap until a match or a hole; a full lap leaves home
					for (n = 0; n < SLOTS && hit < 0; n++) begin
						if (slot_mem[p] == '0) begin
							hit = 0;
							at = p;
						end else if (slot_mem[p] == e) begin
							hit = 1;
							at = p;
						end else begin
							p = (p + 1) % SLOTS;
						end
					end
					cur_pos = at;
					cur_set = 1'b1;
					o.slot = at[SLOT_W-1:0];
					if (hit == 1) begin
						o.entry_out = slot_mem[at];
						o.status = (w.mode == MODE_ADD) ? ST_EXISTS : ST_OK;
					end else if (w.mode == MODE_FIND) begin
						o.status = ST_NOT_FOUND;
					end else if (hit < 0 || n_stored > thresh || n_stored >= SLOTS) begin
						o.status = ST_FULL;
					end else begin
						slot_mem[at] = e;
						n_stored++;
						o.status = ST_OK;
					end
				end
			end
			MODE_FIRST, MODE_NEXT: begin
				// next without a position starts from the bottom like first
				p = (w.mode == MODE_NEXT && cur_set) ? cur_pos + 1 : 0;
				while (p < SLOTS && slot_mem[p] == '0)
					p++;
				if (p < SLOTS) begin
					cur_pos = p;
					cur_set = 1'b1;
					o.entry_out = slot_mem[p];
					o.slot = p[SLOT_W-1:0];
					o.status = ST_OK;
				end else begin
					o.slot = SLOT_W'(SLOTS - 1);
					o.status = ST_END;
				end
			end
			MODE_LAST: begin
				p = SLOTS - 1;
				while (p >= 0 && slot_mem[p] == '0)
					p--;
				if (p >= 0) begin
					cur_pos = p;
					cur_set = 1'b1;
					o.entry_out = slot_mem[p];
					o.slot = p[SLOT_W-1:0];
					o.status = ST_OK;
				end else begin
					o.status = ST_END;
				end
			end
			default: begin
				o.slot = cur_pos[SLOT_W-1:0];
			end
		endcase
		o.count = n_stored[COUNT_W-1:0];
		return o;
	endfunction

	// Fresh entry whose home slot is h; the upper bits keep entries on one home distinct.
	function automatic logic [63:0] entry_at_home(int h);
		logic [63:0] e;
		e = {$urandom, $urandom};
		e[SLOT_W-1:0] = h[SLOT_W-1:0];
		if (e == '0)
			e[63] = 1'b1;
		return e;
	endfunction

	// A quarter of fresh entries crowd the ends of the table, so probes collide and wrap.
	function automatic logic [63:0] fresh_entry();
		int h;
		if ($urandom_range(99) < 25) begin
			h = $urandom_range(15);
			if (h >= 8)
				h += SLOTS - 16;
		end else begin
			h = $urandom_range(SLOTS - 1);
		end
		return entry_at_home(h);
	endfunction

	task automatic push_word(logic [MODE_W-1:0] m, logic [63:0] e);
		item_in_t w;
		w.mode = m;
		w.entry = e;
		word_q.push_back(w);
		pending_results++;
		if (m == MODE_ADD && e != '0)
			added_q.push_back(e);
	endtask

	task automatic push_rand();
		int          r;
		logic [63:0] known;
		r = $urandom_range(99);
		known = (added_q.size() != 0) ?
			added_q[$urandom_range(added_q.size() - 1)] : fresh_entry();
		if (r < 30)
			push_word(MODE_ADD, fresh_entry());
		else if (r < 40)
			push_word(MODE_ADD, known);
		else if (r < 60)
			push_word(MODE_FIND, known);
		else if (r < 68)
			push_word(MODE_FIND, fresh_entry());
		else if (r < 76)
			push_word(MODE_FIRST, {$urandom, $urandom});
		else if (r < 90)
			push_word(MODE_NEXT, {$urandom, $urandom});
		else if (r < 94)
			push_word(MODE_LAST, {$urandom, $urandom});
		else if (r < 97)
			push_word($urandom_range(1) ? MODE_ADD : MODE_FIND, '0);
		else
			push_word($urandom_range(2) == 0 ? MODE_RSVD5 :
				($urandom_range(1) ? MODE_RSVD6 : MODE_RSVD7), {$urandom, $urandom});
	endtask

	task automatic set_idling(int gap_pct, int stall_pct);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
	endtask

	// Hold until every owed result is back, then let the block settle.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the load threshold; only called with the set idle, so the model follows at once.
	task automatic write_threshold(logic [THRESH_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		thresh = v;
	endtask

	task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want_v);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want_v, $realtime);
		n_mismatch++;
	endtask

	// Word feed: log the word taken at this edge, then offer the next one or idle.
	// A word still waiting keeps valid and payload as they are.
	always @(posedge clk) begin : word_feed
		if (arst_n) begin
			if (in_valid && in_ready)
				result_q.push_back(apply_op(in_item));
			if (in_valid && !in_ready) begin
				// hold the offered word
			end else if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_item <= word_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result check: compare each taken result with the oldest owed one, field by field.
	always @(posedge clk) begin : result_check
		item_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					flag_mismatch("result with none owed, status", 64'(out_item.status), '0);
				end else begin
					want = result_q.pop_front();
					pending_results--;
					if (out_item.status !== want.status)
						flag_mismatch("status", 64'(out_item.status), 64'(want.status));
					if (out_item.entry_out !== want.entry_out)
						flag_mismatch("entry_out", out_item.entry_out, want.entry_out);
					if (out_item.slot !== want.slot)
						flag_mismatch("slot", 64'(out_item.slot), 64'(want.slot));
					if (out_item.count !== want.count)
						flag_mismatch("count", 64'(out_item.count), 64'(want.count));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : stimulus
		foreach (slot_mem[i])
			slot_mem[i] = '0;
		n_stored = 0;
		cur_pos = 0;
		cur_set = 1'b0;
		thresh = THRESH_RST;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words on the empty table, default threshold, no idling.
		// Scans of an empty table, a position-less next and a reserved mode first.
		push_word(MODE_LAST, '0);
		push_word(MODE_FIRST, '0);
		push_word(MODE_NEXT, '1);
		push_word(MODE_RSVD5, '1);
		// zero entries are refused for both lookups
		push_word(MODE_ADD, '0);
		push_word(MODE_FIND, '0);
		push_word(MODE_FIND, 64'h1);
		// all-ones lands on the top slot; a second entry on the same home wraps to slot 0
		push_word(MODE_ADD, '1);
		push_word(MODE_ADD, 64'h0000_00A5_0000_01FF);
		push_word(MODE_ADD, 64'h1);
		push_word(MODE_ADD, 64'h1);
		push_word(MODE_FIND, '1);
		push_word(MODE_ADD, 64'h8000_0000_0000_0001);
		push_word(MODE_FIND, 64'h4000_0000_0000_0001);
		// walk the occupied slots up to the end, then step past the top slot
		push_word(MODE_FIRST, '0);
		push_word(MODE_NEXT, '0);
		push_word(MODE_NEXT, '0);
		push_word(MODE_NEXT, '0);
		push_word(MODE_NEXT, '0);
		push_word(MODE_LAST, '0);
		push_word(MODE_RSVD7, '0);
		push_word(MODE_RSVD6, 64'h5555_5555_5555_5555);
		// home 0 runs through the wrapped cluster to slot 3
		push_word(MODE_ADD, 64'h8000_0000_0000_0000);
		push_word(MODE_NEXT, '0);
		wait_drained();

		// Threshold zero: every insert is refused, lookups and scans go on.
		write_threshold('0);
		repeat (375) push_rand();
		wait_drained();

		// Low threshold, sender gaps; pause halfway until every result is back.
		write_threshold(THRESH_W'($urandom_range(150, 60)));
		set_idling(47, 0);
		repeat (187) push_rand();
		wait_drained();
		repeat (188) push_rand();
		wait_drained();

		// Mid threshold, receiver stalls.
		write_threshold(THRESH_W'($urandom_range(400, 250)));
		set_idling(0, 47);
		repeat (375) push_rand();
		wait_drained();

		// All low bits set, both sides idling.
		write_threshold(THRESH_W'(SLOTS - 1));
		set_idling(28, 28);
		repeat (375) push_rand();
		wait_drained();

		// Top threshold: fill every hole straight at its home, then work the full table.
		write_threshold(THRESH_W'(SLOTS));
		set_idling(0, 0);
		foreach (slot_mem[i])
			if (slot_mem[i] == '0)
				push_word(MODE_ADD, entry_at_home(i));
		wait_drained();
		set_idling(28, 28);
		repeat (40) push_rand();
		wait_drained();

		if (n_mismatch == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop far beyond the slowest correct run, reset clearing pass included.
	initial begin : watchdog
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
